// ----- src/dwmac_pkg.sv -----
// Shared constants, register indexes and types of the depthwise MAC block.
`default_nettype none
package dwmac_pkg;

	localparam int ACT_WIDTH_DEF    = 8;
	localparam int WEIGHT_WIDTH_DEF = 8;
	localparam int BIAS_WIDTH_DEF   = 16;
	localparam int ACC_WIDTH_DEF    = 32;

	localparam int ROW_WIDTH     = 24;
	localparam int BIAS_IN_WIDTH = 16;
	localparam int OUT_WIDTH     = 8;
	localparam int NUM_ROWS      = 3;
	localparam int NUM_TAPS      = 9;
	localparam int PADDR_WIDTH   = 4;
	localparam int PDATA_WIDTH   = 32;

	typedef enum logic [1:0] {
		REG_MAP_SIGNED = 2'd0,
		REG_BIAS_SHIFT = 2'd1,
		REG_OUT_SHIFT  = 2'd2,
		REG_RELU_ON    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic       map_signed;
		logic [2:0] bias_shift;
		logic [2:0] out_shift;
		logic       relu_on;
	} cfg_t;

	// Row 0 is the top kernel row.
	typedef struct packed {
		logic [NUM_ROWS-1:0][ROW_WIDTH-1:0] act_rows;
		logic [NUM_ROWS-1:0][ROW_WIDTH-1:0] weight_rows;
		logic [BIAS_IN_WIDTH-1:0]           bias;
	} item_t;

endpackage
`default_nettype wire

// ----- src/dwmac_cfg.sv -----
// Configuration register file with its APB-style access port.
`default_nettype none
module dwmac_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dwmac_pkg::PADDR_WIDTH-1:0]  paddr,
	input  logic [dwmac_pkg::PDATA_WIDTH-1:0]  pwdata,
	output logic [dwmac_pkg::PDATA_WIDTH-1:0]  prdata,
	output logic                               pready,
	output dwmac_pkg::cfg_t                    cfg
);
	import dwmac_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_WIDTH-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAP_SIGNED: cfg_q.map_signed <= pwdata[0];
				REG_BIAS_SHIFT: cfg_q.bias_shift <= pwdata[2:0];
				REG_OUT_SHIFT:  cfg_q.out_shift  <= pwdata[2:0];
				REG_RELU_ON:    cfg_q.relu_on    <= pwdata[0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAP_SIGNED: prdata = PDATA_WIDTH'(cfg_q.map_signed);
			REG_BIAS_SHIFT: prdata = PDATA_WIDTH'(cfg_q.bias_shift);
			REG_OUT_SHIFT:  prdata = PDATA_WIDTH'(cfg_q.out_shift);
			REG_RELU_ON:    prdata = PDATA_WIDTH'(cfg_q.relu_on);
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/dwmac_mul.sv -----
// Tap unpacking, the nine activation-weight products and the shifted bias term.
`default_nettype none
module dwmac_mul #(
	parameter int ACT_WIDTH    = dwmac_pkg::ACT_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = dwmac_pkg::WEIGHT_WIDTH_DEF,
	parameter int BIAS_WIDTH   = dwmac_pkg::BIAS_WIDTH_DEF,
	parameter int ACC_WIDTH    = dwmac_pkg::ACC_WIDTH_DEF,
	parameter int PROD_WIDTH   = ACT_WIDTH + WEIGHT_WIDTH + 1
) (
	input  dwmac_pkg::item_t                                 item,
	input  logic                                             map_signed,
	input  logic [2:0]                                       bias_shift,
	output logic [dwmac_pkg::NUM_TAPS-1:0][PROD_WIDTH-1:0]   prod,
	output logic [ACC_WIDTH-1:0]                             bias_acc
);
	import dwmac_pkg::*;

	localparam int EXT_A = ROW_WIDTH + 3 * ACT_WIDTH;
	localparam int EXT_W = ROW_WIDTH + 3 * WEIGHT_WIDTH;
	localparam int BW    = (BIAS_WIDTH < BIAS_IN_WIDTH) ? BIAS_WIDTH : BIAS_IN_WIDTH;

	logic signed [BW-1:0] bias_s;

	// Taps whose slot lies above the packed row read as zero.
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		for (genvar t = 0; t < 3; t++) begin : g_tap
			logic [EXT_A-1:0]               a_row;
			logic [EXT_W-1:0]               w_row;
			logic [ACT_WIDTH-1:0]           a_raw;
			logic signed [ACT_WIDTH:0]      a_ext;
			logic signed [WEIGHT_WIDTH-1:0] w_s;
			logic signed [PROD_WIDTH-1:0]   p_s;

			assign a_row = EXT_A'(item.act_rows[r]);
			assign w_row = EXT_W'(item.weight_rows[r]);
			assign a_raw = a_row[(2 - t) * ACT_WIDTH +: ACT_WIDTH];
			assign a_ext = {map_signed & a_raw[ACT_WIDTH-1], a_raw};
			assign w_s   = w_row[(2 - t) * WEIGHT_WIDTH +: WEIGHT_WIDTH];
			assign p_s   = a_ext * w_s;
			assign prod[r * 3 + t] = p_s;
		end
	end

	assign bias_s   = item.bias[BW-1:0];
	assign bias_acc = ACC_WIDTH'(bias_s) << bias_shift;

endmodule
`default_nettype wire

// ----- src/dwmac_rq.sv -----
// Accumulation of the products, optional ReLU, output shift and saturation.
`default_nettype none
module dwmac_rq #(
	parameter int ACT_WIDTH    = dwmac_pkg::ACT_WIDTH_DEF,
	parameter int ACC_WIDTH    = dwmac_pkg::ACC_WIDTH_DEF,
	parameter int PROD_WIDTH   = 17
) (
	input  logic [dwmac_pkg::NUM_TAPS-1:0][PROD_WIDTH-1:0]   prod,
	input  logic [ACC_WIDTH-1:0]                             bias_acc,
	input  logic [2:0]                                       out_shift,
	input  logic                                             relu_on,
	output logic [dwmac_pkg::OUT_WIDTH-1:0]                  out_value
);
	import dwmac_pkg::*;

	localparam int CW = ACC_WIDTH + 2;
	localparam logic signed [CW-1:0] RELU_HI = CW'((64'd1 << ACT_WIDTH) - 64'd1);
	localparam logic signed [CW-1:0] SAT_HI  = CW'((64'd1 << (ACT_WIDTH - 1)) - 64'd1);
	localparam logic signed [CW-1:0] SAT_LO  = ~SAT_HI;

	logic [NUM_ROWS-1:0][ACC_WIDTH-1:0] row_sum;
	logic signed [ACC_WIDTH-1:0]        acc;
	logic signed [ACC_WIDTH-1:0]        shifted;
	logic signed [CW-1:0]               val;
	logic signed [CW-1:0]               res;

	// Every addition wraps at the accumulator width.
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			row_sum[r] = ACC_WIDTH'(signed'(prod[r * 3]))
				+ ACC_WIDTH'(signed'(prod[r * 3 + 1]))
				+ ACC_WIDTH'(signed'(prod[r * 3 + 2]));
		end
	end

	assign acc     = bias_acc + row_sum[0] + row_sum[1] + row_sum[2];
	assign shifted = acc >>> out_shift;
	assign val     = CW'(shifted);

	always_comb begin
		if (relu_on) begin
			priority if (acc[ACC_WIDTH-1]) begin
				res = '0;
			end else if (val >= RELU_HI) begin
				res = RELU_HI;
			end else begin
				res = val;
			end
		end else begin
			priority if (val >= SAT_HI) begin
				res = SAT_HI;
			end else if (val <= SAT_LO) begin
				res = SAT_LO;
			end else begin
				res = val;
			end
		end
	end

	assign out_value = OUT_WIDTH'(res[ACT_WIDTH-1:0]);

endmodule
`default_nettype wire

// ----- src/depthwise_mac_requantize.sv -----
// Top level of the 3x3 depthwise MAC with requantization.
//
// One input transfer carries nine activations and nine signed weights, packed
// three per kernel row with tap 0 in the high slot, plus one signed bias. One
// output transfer carries the requantized 8-bit result for it.
// Both channels use valid/stall: a transfer happens on a rising edge where
// valid is high and stall is low.
// The block is a three-register pipeline: input register, product register
// (nine multipliers and the shifted bias), and output register (accumulate,
// ReLU, shift, saturate). One item is taken every cycle while the output
// flows. When the receiver stalls, the output register holds its result and
// the earlier stages keep filling; in_stall rises only once all stages hold
// items. Reset empties the pipeline and clears the configuration registers
// to zero. Configuration is written through the APB-style port; pready is
// always high. The user must write it only while the pipeline is empty; the
// block itself does not enforce this.
`default_nettype none
module depthwise_mac_requantize #(
	parameter int ACT_WIDTH    = dwmac_pkg::ACT_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = dwmac_pkg::WEIGHT_WIDTH_DEF,
	parameter int BIAS_WIDTH   = dwmac_pkg::BIAS_WIDTH_DEF,
	parameter int ACC_WIDTH    = dwmac_pkg::ACC_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [dwmac_pkg::ROW_WIDTH-1:0]           act_row_top,
	input  logic [dwmac_pkg::ROW_WIDTH-1:0]           act_row_mid,
	input  logic [dwmac_pkg::ROW_WIDTH-1:0]           act_row_bot,
	input  logic [dwmac_pkg::ROW_WIDTH-1:0]           weight_row_top,
	input  logic [dwmac_pkg::ROW_WIDTH-1:0]           weight_row_mid,
	input  logic [dwmac_pkg::ROW_WIDTH-1:0]           weight_row_bot,
	input  logic signed [dwmac_pkg::BIAS_IN_WIDTH-1:0] bias_value,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [dwmac_pkg::OUT_WIDTH-1:0]           out_value,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [dwmac_pkg::PADDR_WIDTH-1:0]         paddr,
	input  logic [dwmac_pkg::PDATA_WIDTH-1:0]         pwdata,
	output logic [dwmac_pkg::PDATA_WIDTH-1:0]         prdata,
	output logic                                      pready
);
	import dwmac_pkg::*;

	localparam int PROD_WIDTH = ACT_WIDTH + WEIGHT_WIDTH + 1;

	cfg_t                                cfg;
	item_t                               in_item;
	item_t                               item_s1;
	logic                                valid_s1;
	logic [NUM_TAPS-1:0][PROD_WIDTH-1:0] prod;
	logic [NUM_TAPS-1:0][PROD_WIDTH-1:0] prod_s2;
	logic [ACC_WIDTH-1:0]                bias_acc;
	logic [ACC_WIDTH-1:0]                bias_acc_s2;
	logic                                valid_s2;
	logic [OUT_WIDTH-1:0]                rq_value;
	logic [OUT_WIDTH-1:0]                out_value_q;
	logic                                out_valid_q;
	logic                                out_free;
	logic                                s2_free;
	logic                                s1_free;
	logic                                in_xfer;

	dwmac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_item.act_rows    = {act_row_bot, act_row_mid, act_row_top};
	assign in_item.weight_rows = {weight_row_bot, weight_row_mid, weight_row_top};
	assign in_item.bias        = bias_value;

	// A stage can take new data when it is empty or its content moves on.
	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;
	assign in_xfer  = in_valid && s1_free;

	dwmac_mul #(
		.ACT_WIDTH    (ACT_WIDTH),
		.WEIGHT_WIDTH (WEIGHT_WIDTH),
		.BIAS_WIDTH   (BIAS_WIDTH),
		.ACC_WIDTH    (ACC_WIDTH),
		.PROD_WIDTH   (PROD_WIDTH)
	) u_mul (
		.item       (item_s1),
		.map_signed (cfg.map_signed),
		.bias_shift (cfg.bias_shift),
		.prod       (prod),
		.bias_acc   (bias_acc)
	);

	dwmac_rq #(
		.ACT_WIDTH  (ACT_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH),
		.PROD_WIDTH (PROD_WIDTH)
	) u_rq (
		.prod      (prod_s2),
		.bias_acc  (bias_acc_s2),
		.out_shift (cfg.out_shift),
		.relu_on   (cfg.relu_on),
		.out_value (rq_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_item;
		end
		if (s2_free && valid_s1) begin
			prod_s2     <= prod;
			bias_acc_s2 <= bias_acc;
		end
		if (out_free && valid_s2) begin
			out_value_q <= rq_value;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

endmodule
`default_nettype wire
